>>> rtl/core/scbh_pkg.sv
// Shared constants and types for the swept circle box hit test.
package scbh_pkg;

  localparam int COORD_W    = 24;  // signed position and velocity fields
  localparam int SIZE_W     = 23;  // box width and height
  localparam int DT_W       = 16;  // time step, Q0.16
  localparam int RAD_W      = 16;  // radius register, Q8.8
  localparam int RAD_FRAC   = 8;
  localparam int TIME_FRAC  = 16;
  localparam int DIST_W     = 27;  // signed edge distance
  localparam int DMAG_W     = DIST_W - 1;
  localparam int VMAG_W     = COORD_W;  // magnitude of a 24-bit signed velocity
  localparam int QUO_W      = DMAG_W + TIME_FRAC;  // quotient magnitude bits
  localparam int TIME_W     = QUO_W + 1;           // signed time
  localparam int ENTRY_W    = 32;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 40;

  // Per-item data that rides along with the divisions.
  typedef struct packed {
    logic            vx_neg;
    logic            vy_neg;
    logic            corner_x;  // x face is nearer on a corner hit
    logic [DT_W-1:0] dt;
  } side_t;

endpackage

>>> rtl/core/scbh_div.sv
// Pipelined signed restoring divider, one quotient bit per stage.
module scbh_div #(
  parameter int QW = 42,
  parameter int VW = 24
) (
  input  logic                clk,
  input  logic                en,
  input  logic [QW-1:0]       num,
  input  logic [VW-1:0]       den,
  input  logic                neg,
  output logic signed [QW:0]  quo
);

  logic [VW-1:0] rem_q [1:QW];
  logic [QW-1:0] num_q [1:QW];
  logic [QW-1:0] quo_q [1:QW];
  logic [VW-1:0] den_q [1:QW];
  logic          neg_q [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [QW-1:0] num_in;
    logic [QW-1:0] quo_in;
    logic [VW-1:0] den_in;
    logic          neg_in;
    logic [VW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign quo_in = '0;
      assign den_in = den;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_q[i];
      assign num_in = num_q[i];
      assign quo_in = quo_q[i];
      assign den_in = den_q[i];
      assign neg_in = neg_q[i];
    end

    assign trial = {rem_in, num_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1] <= take ? VW'(trial - {1'b0, den_in}) : trial[VW-1:0];
        num_q[i+1] <= {num_in[QW-2:0], 1'b0};
        quo_q[i+1] <= {quo_in[QW-2:0], take};
        den_q[i+1] <= den_in;
        neg_q[i+1] <= neg_in;
      end
    end
  end

  // truncate toward zero: negate the magnitude quotient
  assign quo = neg_q[QW] ? -signed'({1'b0, quo_q[QW]}) : signed'({1'b0, quo_q[QW]});

endmodule

>>> rtl/core/swept_circle_box_hit.sv
// Swept circle against widened box hit test, slab method, fully pipelined.
//
// Input stream s_*: one box test per transfer, tdata packs start point,
// velocity, time step and box. Output stream m_*: one result per input, in
// order, with hit flag, unit normal and saturated Q15.16 entry time.
// cfg_wr/cfg_data set the ball radius (Q8.8); write it only while idle.
//
// From input transfer to m_tvalid an item passes two front stages
// for edge distances and magnitudes, 42 stages of the four parallel
// restoring dividers (one quotient bit each), three compare stages and the
// output register. A new item is taken every cycle while the output moves.
//
// The whole pipeline advances together: when m_tvalid is high and m_tready
// low, every stage holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the radius reset value 2048.
module swept_circle_box_hit #(
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_x, start_y, vel_x, vel_y, step_time, box_left, box_top,
  // box_width, box_height, zero pad
  input  logic [scbh_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hit, normal_x, normal_y, entry_time, zero pad
  output logic [scbh_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int DW  = scbh_pkg::DIST_W;
  localparam int MW  = scbh_pkg::DMAG_W;
  localparam int VW  = scbh_pkg::VMAG_W;
  localparam int QW  = scbh_pkg::QUO_W;
  localparam int TW  = scbh_pkg::TIME_W;
  localparam int CW  = scbh_pkg::COORD_W;
  localparam int LAT = QW + 6;
  localparam int SHL = (COORD_FRAC_BITS >= scbh_pkg::RAD_FRAC) ?
                       COORD_FRAC_BITS - scbh_pkg::RAD_FRAC : 0;
  localparam int SHR = (COORD_FRAC_BITS < scbh_pkg::RAD_FRAC) ?
                       scbh_pkg::RAD_FRAC - COORD_FRAC_BITS : 0;

  logic [scbh_pkg::RAD_W-1:0] radius;
  logic [LAT-1:0]             vld;
  logic                       en;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 16'd2048;
    end else if (cfg_wr) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // unpack
  logic signed [CW-1:0]              sx, sy, vx, vy, bl, bt;
  logic [scbh_pkg::DT_W-1:0]         dt_in;
  logic [scbh_pkg::SIZE_W-1:0]       bw, bh;
  assign sx    = signed'(s_tdata[23:0]);
  assign sy    = signed'(s_tdata[47:24]);
  assign vx    = signed'(s_tdata[71:48]);
  assign vy    = signed'(s_tdata[95:72]);
  assign dt_in = s_tdata[111:96];
  assign bl    = signed'(s_tdata[135:112]);
  assign bt    = signed'(s_tdata[159:136]);
  assign bw    = s_tdata[182:160];
  assign bh    = s_tdata[205:183];

  logic [CW-1:0]        r_al;
  logic signed [DW-1:0] r_s;
  assign r_al = (CW'(radius) << SHL) >> SHR;
  assign r_s  = signed'(DW'(r_al));

  // front stage 1: edge distances
  logic signed [DW-1:0] dxl, dxr, dyt, dyb;
  logic signed [CW-1:0] f1_vx, f1_vy;
  logic [scbh_pkg::DT_W-1:0] f1_dt;

  always_ff @(posedge clk) begin
    if (en) begin
      dxl   <= DW'(bl) - r_s - DW'(sx);
      dxr   <= DW'(bl) + signed'(DW'(bw)) + r_s - DW'(sx);
      dyt   <= DW'(bt) - r_s - DW'(sy);
      dyb   <= DW'(bt) + signed'(DW'(bh)) + r_s - DW'(sy);
      f1_vx <= vx;
      f1_vy <= vy;
      f1_dt <= dt_in;
    end
  end

  // front stage 2: magnitudes, quotient signs, corner choice
  logic [MW-1:0] m_xl, m_xr, m_yt, m_yb, c_x, c_y;
  logic [VW-1:0] dvx_m, dvy_m;
  assign m_xl  = dxl[DW-1] ? MW'(-dxl) : MW'(dxl);
  assign m_xr  = dxr[DW-1] ? MW'(-dxr) : MW'(dxr);
  assign m_yt  = dyt[DW-1] ? MW'(-dyt) : MW'(dyt);
  assign m_yb  = dyb[DW-1] ? MW'(-dyb) : MW'(dyb);
  assign c_x   = f1_vx[CW-1] ? m_xl : m_xr;
  assign c_y   = f1_vy[CW-1] ? m_yt : m_yb;
  // a zero velocity divides as one positive LSB
  assign dvx_m = (f1_vx == '0) ? VW'(1) : (f1_vx[CW-1] ? VW'(-f1_vx) : VW'(f1_vx));
  assign dvy_m = (f1_vy == '0) ? VW'(1) : (f1_vy[CW-1] ? VW'(-f1_vy) : VW'(f1_vy));

  logic [QW-1:0]    n_xl, n_xr, n_yt, n_yb;
  logic [VW-1:0]    d_x, d_y;
  logic [3:0]       q_neg;
  scbh_pkg::side_t  side [0:QW+2];

  always_ff @(posedge clk) begin
    if (en) begin
      n_xl <= {m_xl, {scbh_pkg::TIME_FRAC{1'b0}}};
      n_xr <= {m_xr, {scbh_pkg::TIME_FRAC{1'b0}}};
      n_yt <= {m_yt, {scbh_pkg::TIME_FRAC{1'b0}}};
      n_yb <= {m_yb, {scbh_pkg::TIME_FRAC{1'b0}}};
      d_x  <= dvx_m;
      d_y  <= dvy_m;
      q_neg <= {dyb[DW-1] ^ f1_vy[CW-1], dyt[DW-1] ^ f1_vy[CW-1],
                dxr[DW-1] ^ f1_vx[CW-1], dxl[DW-1] ^ f1_vx[CW-1]};
      side[0].vx_neg   <= f1_vx[CW-1];
      side[0].vy_neg   <= f1_vy[CW-1];
      side[0].corner_x <= c_x < c_y;
      side[0].dt       <= f1_dt;
    end
  end

  for (genvar k = 0; k < QW + 2; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side[k+1] <= side[k];
      end
    end
  end

  logic signed [TW-1:0] q_xl, q_xr, q_yt, q_yb;

  scbh_div #(.QW(QW), .VW(VW)) u_div_xl (
    .clk(clk), .en(en), .num(n_xl), .den(d_x), .neg(q_neg[0]), .quo(q_xl));
  scbh_div #(.QW(QW), .VW(VW)) u_div_xr (
    .clk(clk), .en(en), .num(n_xr), .den(d_x), .neg(q_neg[1]), .quo(q_xr));
  scbh_div #(.QW(QW), .VW(VW)) u_div_yt (
    .clk(clk), .en(en), .num(n_yt), .den(d_y), .neg(q_neg[2]), .quo(q_yt));
  scbh_div #(.QW(QW), .VW(VW)) u_div_yb (
    .clk(clk), .en(en), .num(n_yb), .den(d_y), .neg(q_neg[3]), .quo(q_yb));

  // post stages: register times, slab entry/exit, overall entry/exit
  logic signed [TW-1:0] p1_xl, p1_xr, p1_yt, p1_yb;
  logic signed [TW-1:0] enx, exx, eny, exy, t_in, t_out;
  logic                 use_x;
  scbh_pkg::side_t      p3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xl <= q_xl;
      p1_xr <= q_xr;
      p1_yt <= q_yt;
      p1_yb <= q_yb;
      enx <= (p1_xl < p1_xr) ? p1_xl : p1_xr;
      exx <= (p1_xl > p1_xr) ? p1_xl : p1_xr;
      eny <= (p1_yt < p1_yb) ? p1_yt : p1_yb;
      exy <= (p1_yt > p1_yb) ? p1_yt : p1_yb;
      t_in  <= (enx > eny) ? enx : eny;
      t_out <= (exx < exy) ? exx : exy;
      use_x <= (enx == eny) ? side[QW+2].corner_x : (enx > eny);
      p3_side <= side[QW+2];
    end
  end

  logic                 hit_c;
  logic signed [TW-1:0] dt_s;
  logic [31:0]          sat_c;
  assign dt_s  = signed'(TW'(p3_side.dt));
  assign hit_c = !(t_in > t_out || t_out[TW-1] || t_in > dt_s);
  assign sat_c = (t_in > signed'(TW'(32'h7fff_ffff))) ? 32'h7fff_ffff :
                 (t_in < -signed'(TW'(33'h1_0000_0000 >> 1))) ? 32'h8000_0000 :
                 t_in[31:0];

  logic       o_hit;
  logic [1:0] o_nx, o_ny;
  logic [31:0] o_t;

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= hit_c;
      o_nx  <= (hit_c && use_x)  ? (p3_side.vx_neg ? 2'b01 : 2'b11) : 2'b00;
      o_ny  <= (hit_c && !use_x) ? (p3_side.vy_neg ? 2'b01 : 2'b11) : 2'b00;
      o_t   <= hit_c ? sat_c : 32'd0;
    end
  end

  assign m_tdata = {3'b000, o_t, o_ny, o_nx, o_hit};

`ifndef NO_ASSERTIONS
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !o_hit) |-> (o_nx == 2'b00 && o_ny == 2'b00 && o_t == 32'd0))
    else $error("miss result carries nonzero fields");

  a_one_normal: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_hit) |-> ((o_nx != 2'b00) != (o_ny != 2'b00)))
    else $error("hit result needs exactly one normal axis");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(vld)))
    else $error("pipeline moved during stall");
`endif

endmodule

>>> verif/tb_swept_circle_box_hit.sv
// Testbench for the swept circle box hit test: directed and random box tests.
module tb_swept_circle_box_hit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] sx, sy, vx, vy;
    logic [15:0]        dt;
    logic signed [23:0] bl, bt;
    logic [22:0]        bw, bh;
  } box_test_t;

  typedef struct {
    logic               hit;
    logic signed [1:0]  nx, ny;
    logic signed [31:0] entry;
  } hit_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr = 1'b0;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // start_x, start_y, vel_x, vel_y, step_time, box_left, box_top,
  // box_width, box_height, zero pad
  logic [scbh_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // hit, normal_x, normal_y, entry_time, zero pad
  logic [scbh_pkg::OUT_DATA_W-1:0] m_tdata;

  logic [15:0] radius = 16'd2048;
  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  hit_result_t pending_hits[$];

  swept_circle_box_hit u_dut (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [scbh_pkg::IN_DATA_W-1:0] pack_test(box_test_t t);
    return {2'b0, t.bh, t.bw, t.bt, t.bl, t.dt, t.vy, t.vx, t.sy, t.sx};
  endfunction

  function automatic box_test_t unpack_test(logic [scbh_pkg::IN_DATA_W-1:0] d);
    box_test_t t;
    t.sx = d[23:0];    t.sy = d[47:24];
    t.vx = d[71:48];   t.vy = d[95:72];
    t.dt = d[111:96];
    t.bl = d[135:112]; t.bt = d[159:136];
    t.bw = d[182:160]; t.bh = d[205:183];
    return t;
  endfunction

  function automatic longint abs_l(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic hit_result_t predict_hit(box_test_t t, logic [15:0] rad);
    longint r, sx, sy, vx, vy, lft, rgt, top, bot, dvx, dvy;
    longint tx1, tx2, ty1, ty2, enx, exx, eny, exy, t_in, t_out, dx, dy;
    logic use_x;
    hit_result_t res;
    r = rad;
    sx = t.sx; sy = t.sy; vx = t.vx; vy = t.vy;
    lft = longint'(t.bl) - r;
    rgt = longint'(t.bl) + longint'(t.bw) + r;
    top = longint'(t.bt) - r;
    bot = longint'(t.bt) + longint'(t.bh) + r;
    dvx = (vx == 0) ? 1 : vx;
    dvy = (vy == 0) ? 1 : vy;
    tx1 = ((lft - sx) * 65536) / dvx;
    tx2 = ((rgt - sx) * 65536) / dvx;
    ty1 = ((top - sy) * 65536) / dvy;
    ty2 = ((bot - sy) * 65536) / dvy;
    enx = (tx1 < tx2) ? tx1 : tx2;  exx = (tx1 > tx2) ? tx1 : tx2;
    eny = (ty1 < ty2) ? ty1 : ty2;  exy = (ty1 > ty2) ? ty1 : ty2;
    t_in = (enx > eny) ? enx : eny;
    t_out = (exx < exy) ? exx : exy;
    res = '{1'b0, 2'sd0, 2'sd0, 32'sd0};
    if (t_in > t_out || t_out < 0 || t_in > longint'(t.dt)) return res;
    // on a tie of entry times pick the nearer face
    if (enx == eny) begin
      dx = (vx < 0) ? (lft - sx) : (sx - rgt);
      dy = (vy < 0) ? (top - sy) : (sy - bot);
      use_x = abs_l(dx) < abs_l(dy);
    end else begin
      use_x = enx > eny;
    end
    res.hit = 1'b1;
    if (use_x) res.nx = (vx < 0) ? 2'sd1 : -2'sd1;
    else res.ny = (vy < 0) ? 2'sd1 : -2'sd1;
    if (t_in > 64'sd2147483647) res.entry = 32'h7fffffff;
    else if (t_in < -64'sd2147483648) res.entry = 32'h80000000;
    else res.entry = t_in[31:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // input side: predict every transfer
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pending_hits.push_back(predict_hit(unpack_test(s_tdata), radius));
  end

  // output side: compare every transfer with the oldest prediction
  always @(posedge clk) begin
    hit_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[0], 0);
      end else begin
        w = pending_hits.pop_front();
        if (m_tdata[0] !== w.hit) report_mismatch("hit", m_tdata[0], w.hit);
        if ($signed(m_tdata[2:1]) !== w.nx)
          report_mismatch("normal_x", $signed(m_tdata[2:1]), w.nx);
        if ($signed(m_tdata[4:3]) !== w.ny)
          report_mismatch("normal_y", $signed(m_tdata[4:3]), w.ny);
        if ($signed(m_tdata[36:5]) !== w.entry)
          report_mismatch("entry_time", $signed(m_tdata[36:5]), w.entry);
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_test(box_test_t t);
    if ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_test(t);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // write only while the pipeline is empty
  task automatic set_radius(logic [15:0] v);
    cfg_wr <= 1'b1;
    cfg_data <= v;
    radius = v;
    @(posedge clk);
    cfg_wr <= 1'b0;
    @(posedge clk);
  endtask

  function automatic box_test_t random_test();
    box_test_t t;
    int span;
    t.sx = 24'($urandom); t.sy = 24'($urandom);
    t.vx = 24'($urandom); t.vy = 24'($urandom);
    t.dt = 16'($urandom); t.bl = 24'($urandom); t.bt = 24'($urandom);
    t.bw = 23'($urandom); t.bh = 23'($urandom);
    if ($urandom_range(99) < 75) begin
      // aim the point at a box not far away
      span = int'(1 << $urandom_range(16, 6));
      t.bl = 24'(t.sx + $signed($urandom_range(2 * span)) - span);
      t.bt = 24'(t.sy + $signed($urandom_range(2 * span)) - span);
      t.bw = 23'($urandom_range(span));
      t.bh = 23'($urandom_range(span));
      t.vx = 24'(($signed($urandom_range(4 * span)) - 2 * span) * $urandom_range(4, 1));
      t.vy = 24'(($signed($urandom_range(4 * span)) - 2 * span) * $urandom_range(4, 1));
      case ($urandom_range(7))
        0: t.vx = 24'sd0;
        1: t.vy = 24'sd0;
        2: t.vy = t.vx;
        default: ;
      endcase
    end
    return t;
  endfunction

  task automatic test_directed;
    box_test_t t;
    t = '{0, 0, 24'sd256, 24'sd0, 16'hffff, 24'sd1024, -24'sd512, 23'd512, 23'd1024};
    send_test(t);                                   // hit from the left
    t.vx = -24'sd256; t.bl = -24'sd2048; send_test(t); // from the right
    t = '{0, 0, 0, 24'sd256, 16'hffff, -24'sd512, 24'sd1024, 23'd1024, 23'd512};
    send_test(t);                                   // from the top, vx zero
    t.vy = -24'sd256; t.bt = -24'sd2048; send_test(t);
    t = '{0, 0, 24'sd256, 24'sd256, 16'hffff, 24'sd2048, 24'sd2048, 23'd256, 23'd256};
    send_test(t);                                   // exact corner
    t.bl = 24'sd2304; send_test(t);                 // corner, x face farther
    t = '{0, 0, 0, 0, 16'd0, -24'sd256, -24'sd256, 23'd512, 23'd512};
    send_test(t);                                   // inside, both velocities zero
    t = '{0, 0, 24'sd1, 24'sd0, 16'd0, 24'sd4096, 24'sd0, 23'd16, 23'd16};
    send_test(t);                                   // miss
    t = '{0, 0, 24'sd1, 24'sd1, 16'hffff, 24'h7fffff, 24'h7fffff, 23'h7fffff, 23'h7fffff};
    send_test(t);                                   // far box, entry time beyond the time step: miss
    t = '{24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 16'hffff,
          24'h800000, 24'h7fffff, 23'h7fffff, 23'h0};
    send_test(t);
    t = '{24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 16'h0,
          24'h7fffff, 24'h800000, 23'h0, 23'h7fffff};
    send_test(t);
    t = '{0, 0, 24'sd256, 24'sd0, 16'd1, 24'sd0, -24'sd256, 23'd0, 23'd0};
    send_test(t);                                   // starts inside the widened box: hit
    t = '{0, 0, 24'sd256, 24'sd0, 16'd0, -24'sd8192, -24'sd256, 23'd0, 23'd0};
    send_test(t);
    drain();
  endtask

  task automatic test_random(int count, logic [15:0] rad);
    set_radius(rad);
    repeat (count) send_test(random_test());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 10; stall_pct = 77;
    test_directed();
    test_random(275, 16'd0);
    test_random(275, 16'hffff);
    gap_pct = 77; stall_pct = 10;
    test_random(275, 16'd2048);
    test_random(275, 16'($urandom));
    gap_pct = 0; stall_pct = 0;
    test_random(275, 16'd1);
    test_random(275, 16'($urandom_range(4096)));
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
